// ===== hw/rtl/gsd_pkg.sv =====
// ----------------------------------------------------------------------------
// gsd_pkg
// Shared types, codes and helpers for the GDSII stream record deframer.
// ----------------------------------------------------------------------------
package gsd_pkg;

  localparam logic [1:0] KIND_DATA   = 2'd0;
  localparam logic [1:0] KIND_EMPTY  = 2'd1;
  localparam logic [1:0] KIND_ERROR  = 2'd2;

  localparam logic [7:0] ENDLIB_TYPE = 8'h04;

  localparam logic [7:0] DT_NONE     = 8'd0;
  localparam logic [7:0] DT_BITS     = 8'd1;
  localparam logic [7:0] DT_INT16    = 8'd2;
  localparam logic [7:0] DT_INT32    = 8'd3;
  localparam logic [7:0] DT_REAL4    = 8'd4;
  localparam logic [7:0] DT_REAL8    = 8'd5;
  localparam logic [7:0] DT_ASCII    = 8'd6;

  localparam logic [15:0] HDR_BYTES  = 16'd4;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  record_type;
    logic [7:0]  data_type;
    logic [63:0] element_value;
    logic        last_of_record;
    logic        end_of_library;
  } gsd_result_t;

  function automatic logic [3:0] elem_size(input logic [7:0] dt);
    logic [3:0] sz;
    begin
      case (dt)
        DT_BITS:  sz = 4'd2;
        DT_INT16: sz = 4'd2;
        DT_INT32: sz = 4'd4;
        DT_REAL4: sz = 4'd4;
        DT_REAL8: sz = 4'd8;
        DT_ASCII: sz = 4'd1;
        default:  sz = 4'd0;
      endcase
      elem_size = sz;
    end
  endfunction

endpackage

// ===== hw/rtl/gsd_parser.sv =====
// ----------------------------------------------------------------------------
// gsd_parser
// Record header and body parser: one stream byte per cycle, at most one result.
// ----------------------------------------------------------------------------
module gsd_parser (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 byte_valid,
  input  logic [7:0]           byte_data,
  output logic                 res_valid,
  output gsd_pkg::gsd_result_t res
);
  import gsd_pkg::*;

  logic [1:0]  hdr_idx_r,   hdr_idx_nxt;
  logic        in_body_r,   in_body_nxt;
  logic [15:0] rec_len_r,   rec_len_nxt;
  logic [7:0]  rtype_r,     rtype_nxt;
  logic [7:0]  data_type_r, data_type_nxt;
  logic [15:0] bytes_rem_r, bytes_rem_nxt;
  logic [2:0]  elem_cnt_r,  elem_cnt_nxt;
  logic [63:0] acc_r,       acc_nxt;
  logic        lib_done_r,  lib_done_nxt;

  logic [15:0] body_len;
  logic [3:0]  hdr_sz;
  logic [3:0]  body_sz;
  logic [3:0]  cnt_inc;
  logic [63:0] acc_shift;
  logic [15:0] rem_dec;
  logic [63:0] elem_val;
  logic        is_endlib;

  assign body_len  = rec_len_r - HDR_BYTES;
  assign hdr_sz    = elem_size(byte_data);
  assign body_sz   = elem_size(data_type_r);
  assign cnt_inc   = {1'b0, elem_cnt_r} + 4'd1;
  assign acc_shift = {acc_r[55:0], byte_data};
  assign rem_dec   = bytes_rem_r - 16'd1;
  assign is_endlib = (rtype_r == ENDLIB_TYPE);

  always_comb begin
    elem_val = acc_shift;
    if (data_type_r == DT_INT16) begin
      elem_val = {{48{acc_shift[15]}}, acc_shift[15:0]};
    end else if (data_type_r == DT_INT32) begin
      elem_val = {{32{acc_shift[31]}}, acc_shift[31:0]};
    end
  end

  always_comb begin
    hdr_idx_nxt   = hdr_idx_r;
    in_body_nxt   = in_body_r;
    rec_len_nxt   = rec_len_r;
    rtype_nxt     = rtype_r;
    data_type_nxt = data_type_r;
    bytes_rem_nxt = bytes_rem_r;
    elem_cnt_nxt  = elem_cnt_r;
    acc_nxt       = acc_r;
    lib_done_nxt  = lib_done_r;

    res_valid          = 1'b0;
    res.kind           = KIND_DATA;
    res.record_type    = rtype_r;
    res.data_type      = data_type_r;
    res.element_value  = '0;
    res.last_of_record = 1'b0;
    res.end_of_library = is_endlib;

    if (byte_valid && !lib_done_r) begin
      if (!in_body_r) begin
        hdr_idx_nxt = hdr_idx_r + 2'd1;
        case (hdr_idx_r)
          2'd0: rec_len_nxt = {byte_data, 8'h00};
          2'd1: rec_len_nxt = {rec_len_r[15:8], byte_data};
          2'd2: rtype_nxt = byte_data;
          default: begin
            data_type_nxt      = byte_data;
            elem_cnt_nxt       = '0;
            acc_nxt            = '0;
            res.data_type      = byte_data;
            res.last_of_record = 1'b1;
            if (rec_len_r < HDR_BYTES) begin
              res_valid     = 1'b1;
              res.kind      = KIND_ERROR;
              in_body_nxt   = 1'b0;
              bytes_rem_nxt = '0;
              if (is_endlib) begin
                lib_done_nxt = 1'b1;
              end
            end else begin
              if (byte_data > DT_ASCII) begin
                res_valid = 1'b1;
                res.kind  = KIND_ERROR;
              end else if (hdr_sz == 4'd0 || body_len < {12'd0, hdr_sz}) begin
                res_valid = 1'b1;
                res.kind  = KIND_EMPTY;
              end
              if (body_len != 16'd0) begin
                in_body_nxt   = 1'b1;
                bytes_rem_nxt = body_len;
              end else begin
                in_body_nxt   = 1'b0;
                bytes_rem_nxt = '0;
                if (is_endlib) begin
                  lib_done_nxt = 1'b1;
                end
              end
            end
          end
        endcase
      end else begin
        acc_nxt       = acc_shift;
        bytes_rem_nxt = rem_dec;
        elem_cnt_nxt  = cnt_inc[2:0];
        if (body_sz != 4'd0 && cnt_inc == body_sz) begin
          res_valid          = 1'b1;
          res.kind           = KIND_DATA;
          res.element_value  = elem_val;
          res.last_of_record = (rem_dec < {12'd0, body_sz});
          elem_cnt_nxt       = '0;
          acc_nxt            = '0;
        end
        if (rem_dec == 16'd0) begin
          in_body_nxt   = 1'b0;
          bytes_rem_nxt = '0;
          elem_cnt_nxt  = '0;
          acc_nxt       = '0;
          if (is_endlib) begin
            lib_done_nxt = 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hdr_idx_r   <= '0;
      in_body_r   <= 1'b0;
      rec_len_r   <= '0;
      rtype_r     <= '0;
      data_type_r <= '0;
      bytes_rem_r <= '0;
      elem_cnt_r  <= '0;
      acc_r       <= '0;
      lib_done_r  <= 1'b0;
    end else begin
      hdr_idx_r   <= hdr_idx_nxt;
      in_body_r   <= in_body_nxt;
      rec_len_r   <= rec_len_nxt;
      rtype_r     <= rtype_nxt;
      data_type_r <= data_type_nxt;
      bytes_rem_r <= bytes_rem_nxt;
      elem_cnt_r  <= elem_cnt_nxt;
      acc_r       <= acc_nxt;
      lib_done_r  <= lib_done_nxt;
    end
  end

endmodule

// ===== hw/rtl/gsd_out_buf.sv =====
// ----------------------------------------------------------------------------
// gsd_out_buf
// Result register with a skid stage toward the stalling receiver.
// ----------------------------------------------------------------------------
module gsd_out_buf (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push_valid,
  input  gsd_pkg::gsd_result_t push_data,
  output logic                 push_ready,
  output logic                 out_valid,
  input  logic                 out_stall,
  output gsd_pkg::gsd_result_t out_data
);
  import gsd_pkg::*;

  logic        out_valid_r,  out_valid_nxt;
  logic        skid_valid_r, skid_valid_nxt;
  gsd_result_t out_data_r,   out_data_nxt;
  gsd_result_t skid_data_r,  skid_data_nxt;
  logic        pop;

  assign pop        = out_valid_r && !out_stall;
  assign push_ready = !skid_valid_r;
  assign out_valid  = out_valid_r;
  assign out_data   = out_data_r;

  always_comb begin
    out_valid_nxt  = out_valid_r;
    skid_valid_nxt = skid_valid_r;
    out_data_nxt   = out_data_r;
    skid_data_nxt  = skid_data_r;
    if (skid_valid_r) begin
      if (pop) begin
        out_valid_nxt  = 1'b1;
        out_data_nxt   = skid_data_r;
        skid_valid_nxt = 1'b0;
      end
    end else if (push_valid) begin
      if (!out_valid_r || pop) begin
        out_valid_nxt = 1'b1;
        out_data_nxt  = push_data;
      end else begin
        skid_valid_nxt = 1'b1;
        skid_data_nxt  = push_data;
      end
    end else if (pop) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r  <= out_data_nxt;
    skid_data_r <= skid_data_nxt;
  end

endmodule

// ===== hw/rtl/gds_stream_record_deframer.sv =====
// ----------------------------------------------------------------------------
// gds_stream_record_deframer
// GDSII stream deframer: bytes in, one result per element or record event.
// ----------------------------------------------------------------------------
// Input channel: one stream byte per transfer (in_valid / in_stall).
// Result channel: zero or one result per byte (out_valid / out_stall):
// data elements, empty-record markers and header errors, each tagged with
// the record and data type, last-of-record and end-of-library flags.
// Throughput is one byte per cycle while in_stall is low; the parser sits
// combinationally between the input register and the result register and
// updates its counters and shift accumulator with each byte.
// Path: the completing byte is held in the input register, the parser forms
// the result, and the result register drives it on out_*.
// Reset clears the parser to the start of a header and empties all stages.
// When the receiver stalls, the result register holds, a skid stage takes
// one more result, and then in_stall rises until the receiver drains it.
// After an ENDLIB record ends, bytes are taken and dropped until reset.
// ----------------------------------------------------------------------------
module gds_stream_record_deframer (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_stream_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_kind,
  output logic [7:0]  out_record_type,
  output logic [7:0]  out_data_type,
  output logic signed [63:0] out_element_value,
  output logic        out_last_of_record,
  output logic        out_end_of_library
);
  import gsd_pkg::*;

  logic        in_valid_r;
  logic [7:0]  in_byte_r;
  logic        buf_ready;
  logic        fire;
  logic        res_valid;
  gsd_result_t res;
  gsd_result_t out_data;

  assign fire     = in_valid_r && buf_ready;
  assign in_stall = in_valid_r && !buf_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (!in_stall) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_byte_r <= in_stream_byte;
    end
  end

  gsd_parser u_parser (
    .clk        (clk),
    .rst_n      (rst_n),
    .byte_valid (fire),
    .byte_data  (in_byte_r),
    .res_valid  (res_valid),
    .res        (res)
  );

  gsd_out_buf u_out_buf (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (res_valid),
    .push_data  (res),
    .push_ready (buf_ready),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data)
  );

  assign out_kind           = out_data.kind;
  assign out_record_type    = out_data.record_type;
  assign out_data_type      = out_data.data_type;
  assign out_element_value  = out_data.element_value;
  assign out_last_of_record = out_data.last_of_record;
  assign out_end_of_library = out_data.end_of_library;

endmodule

// ===== hw/rtl/gsd_checker.sv =====
// ----------------------------------------------------------------------------
// gsd_checker
// Port-level checks for the GDSII stream record deframer.
// ----------------------------------------------------------------------------
module gsd_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_stall,
  input logic [1:0]  out_kind,
  input logic [7:0]  out_record_type,
  input logic [7:0]  out_data_type,
  input logic [63:0] out_element_value,
  input logic        out_last_of_record,
  input logic        out_end_of_library
);
  import gsd_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  a_kind_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_kind == KIND_DATA || out_kind == KIND_EMPTY ||
                   out_kind == KIND_ERROR))
    else $error("illegal result kind");

  a_event_closes: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_kind == KIND_EMPTY || out_kind == KIND_ERROR) |->
      out_last_of_record && (out_element_value == 64'd0))
    else $error("marker or error result not closing its record");

  a_endlib_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_end_of_library == (out_record_type == ENDLIB_TYPE)))
    else $error("end-of-library flag mismatch");

  a_data_type: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_kind == KIND_DATA) |->
      (out_data_type >= DT_BITS && out_data_type <= DT_ASCII))
    else $error("data element with a data type that has no elements");

endmodule

bind gds_stream_record_deframer gsd_checker u_gsd_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .out_valid          (out_valid),
  .out_stall          (out_stall),
  .out_kind           (out_kind),
  .out_record_type    (out_record_type),
  .out_data_type      (out_data_type),
  .out_element_value  (out_element_value),
  .out_last_of_record (out_last_of_record),
  .out_end_of_library (out_end_of_library)
);

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for gds_stream_record_deframer.
// Feeds directed and random GDSII records one byte per transfer, predicts the
// element, marker and error results in a scoreboard, and compares every
// accepted result field by field. Both channels idle and stall at random.
// ----------------------------------------------------------------------------
module tb;
  import gsd_pkg::*;

  localparam int LIMIT_CYCLES = 1000000;
  localparam int RANDOM_BYTES = 730;
  localparam int IDLE_PCT     = 36;

  class deframe_scoreboard;
    logic [1:0]   hdr_idx;
    logic         in_body;
    logic [15:0]  rec_len;
    logic [7:0]   cur_rtype;
    logic [7:0]   data_type;
    logic [15:0]  remaining;
    int           elem_cnt;
    logic [63:0]  acc;
    logic         lib_done;
    gsd_result_t  expected_results[$];
    int           errors;

    function new();
      hdr_idx   = '0;
      in_body   = 1'b0;
      rec_len   = '0;
      cur_rtype = '0;
      data_type = '0;
      remaining = '0;
      elem_cnt  = 0;
      acc       = '0;
      lib_done  = 1'b0;
      errors    = 0;
    endfunction

    function int width_of(logic [7:0] dt);
      case (dt)
        DT_BITS, DT_INT16: return 2;
        DT_INT32, DT_REAL4: return 4;
        DT_REAL8: return 8;
        DT_ASCII: return 1;
        default: return 0;
      endcase
    endfunction

    function void push(logic [1:0] kind, logic [63:0] value, logic last);
      gsd_result_t r;
      r.kind           = kind;
      r.record_type    = cur_rtype;
      r.data_type      = data_type;
      r.element_value  = value;
      r.last_of_record = last;
      r.end_of_library = (cur_rtype == ENDLIB_TYPE);
      expected_results.insert(expected_results.size(), r);
    endfunction

    function void close_record();
      in_body   = 1'b0;
      remaining = '0;
      elem_cnt  = 0;
      acc       = '0;
      if (cur_rtype == ENDLIB_TYPE) lib_done = 1'b1;
    endfunction

    function void note_byte(logic [7:0] b);
      logic [15:0] body;
      logic [63:0] v;
      int sz;
      if (lib_done) return;
      if (!in_body) begin
        case (hdr_idx)
          2'd0: rec_len = {b, 8'h00};
          2'd1: rec_len[7:0] = b;
          2'd2: cur_rtype = b;
          default: begin
            data_type = b;
            elem_cnt  = 0;
            acc       = '0;
            if (rec_len < HDR_BYTES) begin
              push(KIND_ERROR, 64'd0, 1'b1);
              close_record();
            end else begin
              body = rec_len - HDR_BYTES;
              sz   = width_of(b);
              if (b > DT_ASCII) push(KIND_ERROR, 64'd0, 1'b1);
              else if (sz == 0 || body < sz) push(KIND_EMPTY, 64'd0, 1'b1);
              if (body != 0) begin
                in_body   = 1'b1;
                remaining = body;
              end else begin
                close_record();
              end
            end
          end
        endcase
        hdr_idx = hdr_idx + 2'd1;
        return;
      end
      sz        = width_of(data_type);
      elem_cnt  = elem_cnt + 1;
      acc       = {acc[55:0], b};
      remaining = remaining - 16'd1;
      if (sz != 0 && elem_cnt == sz) begin
        v = acc;
        if (data_type == DT_INT16 && v[15]) v[63:16] = '1;
        else if (data_type == DT_INT32 && v[31]) v[63:32] = '1;
        push(KIND_DATA, v, remaining < sz);
        elem_cnt = 0;
        acc      = '0;
      end
      if (remaining == 0) close_record();
    endfunction

    task report(string msg);
      $display("ERROR at %0t: %s", $realtime, msg);
      errors++;
    endtask

    task check_result(gsd_result_t got);
      gsd_result_t want;
      if (expected_results.size() == 0) begin
        report($sformatf("result with nothing expected: kind %0d value %h",
                         got.kind, got.element_value));
        return;
      end
      want = expected_results.pop_front();
      if (got.kind !== want.kind)
        report($sformatf("kind %0d, expected %0d", got.kind, want.kind));
      if (got.record_type !== want.record_type)
        report($sformatf("record_type %h, expected %h", got.record_type,
                         want.record_type));
      if (got.data_type !== want.data_type)
        report($sformatf("data_type %h, expected %h", got.data_type,
                         want.data_type));
      if (got.element_value !== want.element_value)
        report($sformatf("element_value %h, expected %h", got.element_value,
                         want.element_value));
      if (got.last_of_record !== want.last_of_record)
        report($sformatf("last_of_record %b, expected %b", got.last_of_record,
                         want.last_of_record));
      if (got.end_of_library !== want.end_of_library)
        report($sformatf("end_of_library %b, expected %b", got.end_of_library,
                         want.end_of_library));
    endtask
  endclass

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  logic [7:0]         in_stream_byte;
  logic               out_valid;
  logic               out_stall;
  logic [1:0]         out_kind;
  logic [7:0]         out_record_type;
  logic [7:0]         out_data_type;
  logic signed [63:0] out_element_value;
  logic               out_last_of_record;
  logic               out_end_of_library;

  deframe_scoreboard sb;
  int                bytes_sent;
  logic              calm;
  int                cycles;

  gds_stream_record_deframer uut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_stream_byte    (in_stream_byte),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_kind          (out_kind),
    .out_record_type   (out_record_type),
    .out_data_type     (out_data_type),
    .out_element_value (out_element_value),
    .out_last_of_record(out_last_of_record),
    .out_end_of_library(out_end_of_library)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("FAIL gds_stream_record_deframer");
      $finish;
    end
  end

  // Receiver back-pressure.
  always @(negedge clk) begin
    if (!rst_n || calm) out_stall <= 1'b0;
    else out_stall <= ($urandom_range(0, 99) < IDLE_PCT);
  end

  // Transfer monitor.
  always @(posedge clk) begin
    gsd_result_t got;
    if (rst_n) begin
      if (in_valid && !in_stall) sb.note_byte(in_stream_byte);
      if (out_valid && !out_stall) begin
        got.kind           = out_kind;
        got.record_type    = out_record_type;
        got.data_type      = out_data_type;
        got.element_value  = out_element_value;
        got.last_of_record = out_last_of_record;
        got.end_of_library = out_end_of_library;
        sb.check_result(got);
      end
    end
  end

  // Called at a falling edge; returns at the falling edge after the transfer.
  task automatic send_byte(input logic [7:0] b);
    while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid       <= 1'b1;
    in_stream_byte <= b;
    do @(posedge clk); while (in_stall);
    bytes_sent++;
    calm = (bytes_sent >= 300 && bytes_sent < 450);
    @(negedge clk);
  endtask

  task automatic send_record(input logic [15:0] len, input logic [7:0] rtype,
                             input logic [7:0] dtype);
    send_byte(len[15:8]);
    send_byte(len[7:0]);
    send_byte(rtype);
    send_byte(dtype);
    if (len > HDR_BYTES)
      for (int i = 0; i < len - HDR_BYTES; i++)
        send_byte(8'($urandom_range(0, 255)));
  endtask

  task automatic send_bytes(input logic [7:0] body[$]);
    foreach (body[i]) send_byte(body[i]);
  endtask

  task automatic random_records();
    int r;
    int sz;
    int n;
    logic [7:0]  rt;
    logic [7:0]  dt;
    logic [15:0] len;
    bit big_done;
    big_done = 1'b0;
    while (bytes_sent < RANDOM_BYTES) begin
      r  = $urandom_range(0, 99);
      rt = 8'($urandom_range(0, 255));
      if (rt == ENDLIB_TYPE) rt = 8'h05;
      if (!big_done && bytes_sent > 400) begin
        // Long record with a nonzero upper length byte.
        big_done = 1'b1;
        send_record(16'h0100 + 16'($urandom_range(0, 15)), rt, DT_ASCII);
      end else if (r < 80) begin
        dt = 8'($urandom_range(0, 6));
        case (dt)
          DT_BITS, DT_INT16: sz = 2;
          DT_INT32, DT_REAL4: sz = 4;
          DT_REAL8: sz = 8;
          DT_ASCII: sz = 1;
          default: sz = 0;
        endcase
        if (sz == 0) begin
          len = 16'd4 + 16'($urandom_range(0, 5));
        end else begin
          n   = $urandom_range(0, 6);
          len = 16'd4 + 16'(sz * n);
          if ($urandom_range(0, 1)) len = len + 16'($urandom_range(0, sz - 1));
        end
        send_record(len, rt, dt);
      end else if (r < 90) begin
        send_record(16'($urandom_range(0, 3)), rt, 8'($urandom_range(0, 255)));
      end else begin
        send_record(16'd4 + 16'($urandom_range(0, 6)), rt, 8'($urandom_range(7, 255)));
      end
    end
  endtask

  initial begin
    sb             = new();
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_stream_byte = 8'h00;
    bytes_sent     = 0;
    calm           = 1'b0;
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Short length, unknown type, empty and under-filled bodies.
    send_bytes('{8'h00, 8'h02, 8'h10, 8'h03});
    send_bytes('{8'h00, 8'h00, 8'h10, 8'h00});
    send_bytes('{8'h00, 8'h05, 8'h11, 8'h07, 8'hAA});
    send_bytes('{8'h00, 8'h04, 8'h00, DT_NONE});
    send_bytes('{8'h00, 8'h06, 8'h0D, DT_NONE, 8'h12, 8'h34});
    send_bytes('{8'h00, 8'h05, 8'h0D, DT_INT32, 8'h12});
    // Signed extremes, trailing partial element, other data types, unknown type.
    send_bytes('{8'h00, 8'h07, 8'h0D, DT_INT16, 8'h80, 8'h00, 8'hEE});
    send_bytes('{8'h00, 8'h06, 8'h0D, DT_INT16, 8'h7F, 8'hFF});
    send_bytes('{8'h00, 8'h0C, 8'h0D, DT_INT32, 8'h80, 8'h00, 8'h00, 8'h00,
                 8'h7F, 8'hFF, 8'hFF, 8'hFF});
    send_bytes('{8'h00, 8'h06, 8'h11, DT_BITS, 8'hFF, 8'hFF});
    send_bytes('{8'h00, 8'h08, 8'h11, DT_REAL4, 8'hFF, 8'h00, 8'h00, 8'h01});
    send_bytes('{8'h00, 8'h0C, 8'hFF, DT_REAL8, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
                 8'hFF, 8'hFF, 8'hFF, 8'hFF});
    send_bytes('{8'h00, 8'h07, 8'h06, DT_ASCII, 8'h41, 8'h42, 8'h43});
    send_bytes('{8'h00, 8'h05, 8'hFF, 8'hFF, 8'h55});

    bytes_sent = 0;
    random_records();

    // Close the library, then trail bytes that must be dropped.
    send_record(16'd4 + 16'(2 * $urandom_range(0, 2)), ENDLIB_TYPE, DT_INT16);
    repeat (20) send_byte(8'($urandom_range(0, 255)));
    in_valid <= 1'b0;

    while (sb.expected_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (sb.errors == 0 && sb.expected_results.size() == 0)
      $display("PASS gds_stream_record_deframer");
    else
      $display("FAIL gds_stream_record_deframer");
    $finish;
  end

endmodule
